/* sv/bcmb_pkg.sv */
// Package for the byte command memory bridge: memory sizing, register reset values,
// command decode, reply kinds. Used by interfaces and top level; depends on nothing.
`default_nettype none

package bcmb_pkg;

    // Byte store sizing
    localparam int MEM_DEPTH = 4096;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // Field and register widths
    localparam int BYTE_W    = 8;
    localparam int ADDR_W    = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 64;

    // Register reset values
    localparam logic [39:0] OPCODES_RST   = 40'd21542142465;
    localparam logic [15:0] REPLY_RST     = 16'hFF01;
    localparam logic [63:0] PROPS_HI_RST  = 64'd0;
    localparam logic [31:0] PROPS_LO_RST  = 32'd0;
    localparam logic [23:0] MEM_SIZE_RST  = 24'd4096;

    // Erased memory value, also returned for reads outside the store
    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OPCODES  = 3'd0,
        CFG_REPLY    = 3'd1,
        CFG_PROPS_HI = 3'd2,
        CFG_PROPS_LO = 3'd3,
        CFG_MEM_SIZE = 3'd4
    } t_cfg_idx;

    // Decoded command action, in priority order
    typedef enum logic [2:0] {
        ACT_PROPS = 3'd0,
        ACT_SIZE  = 3'd1,
        ACT_CLEAR = 3'd2,
        ACT_READ  = 3'd3,
        ACT_WRITE = 3'd4,
        ACT_NONE  = 3'd5
    } t_act;

    // Kind of reply burst the emitter is sending
    typedef enum logic [2:0] {
        RPL_PROPS   = 3'd0,  // ack + 12 property bytes
        RPL_SIZE    = 3'd1,  // ack + 3 size bytes
        RPL_ACK     = 3'd2,  // ack only
        RPL_UNIMP   = 3'd3,  // unimplemented reply only
        RPL_ACK_MEM = 3'd4,  // ack + memory byte
        RPL_MEM     = 3'd5   // memory byte only
    } t_reply;

    // Opcode byte k out of the packed opcode register
    function automatic logic [7:0] opcode_of(input logic [39:0] codes, input t_act k);
        logic [7:0] b;
        unique case (k)
            ACT_PROPS: b = codes[7:0];
            ACT_SIZE:  b = codes[15:8];
            ACT_CLEAR: b = codes[23:16];
            ACT_READ:  b = codes[31:24];
            ACT_WRITE: b = codes[39:32];
            default:   b = 8'h00;
        endcase
        return b;
    endfunction

    // First matching opcode wins, properties first
    function automatic t_act decode_cmd(input logic [39:0] codes, input logic [7:0] cmd);
        t_act a;
        a = ACT_NONE;
        for (int k = 4; k >= 0; k--) begin
            if (cmd == codes[8*k +: 8]) begin
                a = t_act'(3'(k));
            end
        end
        return a;
    endfunction

    // Index of the final byte of a reply burst
    function automatic logic [3:0] last_index(input t_reply kind);
        logic [3:0] n;
        unique case (kind)
            RPL_PROPS:   n = 4'd12;
            RPL_SIZE:    n = 4'd3;
            RPL_ACK_MEM: n = 4'd1;
            default:     n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

/* sv/bcmb_rx_if.sv */
// Receive channel of the byte command memory bridge: one byte per item.
// Depends on bcmb_pkg for the byte width.
`default_nettype none

interface bcmb_rx_if;
    logic                         valid;
    logic                         ready;
    logic [bcmb_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* sv/bcmb_tx_if.sv */
// Transmit channel of the byte command memory bridge: one reply byte per item
// plus an end-of-reply flag. Depends on bcmb_pkg for the byte width.
`default_nettype none

interface bcmb_tx_if;
    logic                         valid;
    logic                         ready;
    logic [bcmb_pkg::BYTE_W-1:0]  tx_byte;
    logic                         last_of_reply;

    modport source (output valid, output tx_byte, output last_of_reply, input ready);
    modport sink   (input valid, input tx_byte, input last_of_reply, output ready);
endinterface

`default_nettype wire

/* sv/bcmb_ram.sv */
// Generic single-port RAM with registered read data; read data holds between reads.
// Standalone, no package dependency.
`default_nettype none

module bcmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                                   i_clk,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic                                   i_we,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    output      logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read on one address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

/* sv/byte_command_memory_bridge.sv */
// Top level of the byte command memory bridge: command decode, address capture,
// byte store access and reply emitter. Depends on bcmb_pkg, bcmb_rx_if, bcmb_tx_if, bcmb_ram.
//
//  Channel  Dir  Handshake        Payload
//  i_rx     in   valid/ready      rx_byte[7:0]
//  o_tx     out  valid/ready      tx_byte[7:0], last_of_reply
//  i_cfg_*  in   write enable     i_cfg_idx[2:0], i_cfg_wdata[63:0]
//
// Each received byte has its memory access on the edge that accepts it.
// Replies leave the emitter one byte per cycle while o_tx is ready (13 bytes for properties),
// and a new byte is taken in the cycle the last reply byte of the previous one leaves.
// After reset a clearing pass writes 0xFF to all MEM_DEPTH (4096) entries, one per
// cycle; no byte is taken until it ends, configuration writes are taken throughout.
// A stalled o_tx holds the reply byte and blocks i_rx only when a reply is pending.
`default_nettype none

module byte_command_memory_bridge (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    bcmb_rx_if.sink                                    i_rx,
    bcmb_tx_if.source                                  o_tx,
    input  wire logic                                  i_cfg_we,
    input  wire logic [bcmb_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [bcmb_pkg::CFG_DW-1:0]           i_cfg_wdata
);

    localparam int AW = bcmb_pkg::MEM_AW;

    // Configuration registers
    logic [39:0] r_opcodes;
    logic [15:0] r_reply;
    logic [63:0] r_props_hi;
    logic [31:0] r_props_lo;
    logic [23:0] r_mem_size;

    // Command state
    logic [7:0]  r_cur,  n_cur;
    logic [2:0]  r_rem,  n_rem;
    logic        r_seq,  n_seq;
    logic [23:0] r_addr, n_addr;

    // Clearing pass
    logic          r_clr;
    logic [AW-1:0] r_clr_addr;

    // Reply emitter
    logic                 r_busy, n_busy;
    bcmb_pkg::t_reply     r_kind, n_kind;
    logic [3:0]           r_idx,  n_idx;
    logic                 r_oor,  n_oor;

    // Per-item decode results
    bcmb_pkg::t_act   act_rx, act_cur;
    bcmb_pkg::t_reply job_kind;
    logic             job_reply;
    logic [23:0]      op_addr, addr_inc;
    logic             op_rd, op_wr, op_in;

    // Handshakes
    logic in_fire, out_fire, job_done;

    // Memory port
    logic [AW-1:0] mem_addr;
    logic          mem_we, mem_re;
    logic [7:0]    mem_wdata, mem_rdata;

    assign out_fire = o_tx.valid && o_tx.ready;
    assign job_done = out_fire && (r_idx == bcmb_pkg::last_index(r_kind));
    assign i_rx.ready = !r_clr && (!r_busy || job_done);
    assign in_fire = i_rx.valid && i_rx.ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opcodes  <= bcmb_pkg::OPCODES_RST;
            r_reply    <= bcmb_pkg::REPLY_RST;
            r_props_hi <= bcmb_pkg::PROPS_HI_RST;
            r_props_lo <= bcmb_pkg::PROPS_LO_RST;
            r_mem_size <= bcmb_pkg::MEM_SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (bcmb_pkg::t_cfg_idx'(i_cfg_idx))
                bcmb_pkg::CFG_OPCODES:  r_opcodes  <= i_cfg_wdata[39:0];
                bcmb_pkg::CFG_REPLY:    r_reply    <= i_cfg_wdata[15:0];
                bcmb_pkg::CFG_PROPS_HI: r_props_hi <= i_cfg_wdata;
                bcmb_pkg::CFG_PROPS_LO: r_props_lo <= i_cfg_wdata[31:0];
                bcmb_pkg::CFG_MEM_SIZE: r_mem_size <= i_cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    // Command decode and address capture for the received byte
    always_comb begin
        n_cur     = r_cur;
        n_rem     = r_rem;
        n_seq     = r_seq;
        n_addr    = r_addr;
        op_addr   = r_addr;
        op_rd     = 1'b0;
        op_wr     = 1'b0;
        job_kind  = bcmb_pkg::RPL_ACK;
        job_reply = 1'b0;
        addr_inc  = r_addr + 24'd1;
        act_rx    = bcmb_pkg::decode_cmd(r_opcodes, i_rx.rx_byte);
        act_cur   = bcmb_pkg::decode_cmd(r_opcodes, r_cur);

        if (r_rem == 3'd0) begin
            // New command byte
            n_cur     = i_rx.rx_byte;
            job_reply = 1'b1;
            unique case (act_rx)
                bcmb_pkg::ACT_PROPS: job_kind = bcmb_pkg::RPL_PROPS;
                bcmb_pkg::ACT_SIZE:  job_kind = bcmb_pkg::RPL_SIZE;
                bcmb_pkg::ACT_CLEAR: job_kind = bcmb_pkg::RPL_ACK;
                bcmb_pkg::ACT_READ: begin
                    n_seq = (r_cur == bcmb_pkg::opcode_of(r_opcodes, bcmb_pkg::ACT_READ));
                    if (n_seq) begin
                        n_addr   = addr_inc;
                        op_addr  = addr_inc;
                        op_rd    = 1'b1;
                        job_kind = bcmb_pkg::RPL_ACK_MEM;
                    end else begin
                        n_rem    = 3'd3;
                        job_kind = bcmb_pkg::RPL_ACK;
                    end
                end
                bcmb_pkg::ACT_WRITE: begin
                    n_seq    = (r_cur == bcmb_pkg::opcode_of(r_opcodes, bcmb_pkg::ACT_WRITE));
                    n_rem    = n_seq ? 3'd1 : 3'd4;
                    job_kind = bcmb_pkg::RPL_ACK;
                end
                default: job_kind = bcmb_pkg::RPL_UNIMP;
            endcase
        end else begin
            // Address or data byte of the command in progress
            unique case (act_cur)
                bcmb_pkg::ACT_READ: begin
                    if (r_rem >= 3'd3) begin
                        n_addr = {i_rx.rx_byte, 16'h0000};
                        n_rem  = 3'd2;
                    end else if (r_rem == 3'd2) begin
                        n_addr = {r_addr[23:16], i_rx.rx_byte, 8'h00};
                        n_rem  = 3'd1;
                    end else begin
                        n_addr    = {r_addr[23:8], i_rx.rx_byte};
                        op_addr   = n_addr;
                        op_rd     = 1'b1;
                        job_reply = 1'b1;
                        job_kind  = bcmb_pkg::RPL_MEM;
                        n_rem     = 3'd0;
                    end
                end
                bcmb_pkg::ACT_WRITE: begin
                    if (r_seq) begin
                        n_addr  = addr_inc;
                        op_addr = addr_inc;
                        op_wr   = 1'b1;
                        n_rem   = 3'd0;
                    end else if (r_rem >= 3'd4) begin
                        n_addr = {i_rx.rx_byte, 16'h0000};
                        n_rem  = 3'd3;
                    end else if (r_rem == 3'd3) begin
                        n_addr = {r_addr[23:16], i_rx.rx_byte, 8'h00};
                        n_rem  = 3'd2;
                    end else if (r_rem == 3'd2) begin
                        n_addr = {r_addr[23:8], i_rx.rx_byte};
                        n_rem  = 3'd1;
                    end else begin
                        op_wr = 1'b1;
                        n_rem = 3'd0;
                    end
                end
                default: n_rem = 3'd0;  // opcode changed under the command: drop it
            endcase
        end

        op_in = ({1'b0, op_addr} < 25'(bcmb_pkg::MEM_DEPTH));
    end

    // Byte store port: clearing pass, else the access of the accepted byte
    always_comb begin
        if (r_clr) begin
            mem_addr  = r_clr_addr;
            mem_we    = 1'b1;
            mem_wdata = bcmb_pkg::ERASED_BYTE;
            mem_re    = 1'b0;
        end else begin
            mem_addr  = op_addr[AW-1:0];
            mem_we    = in_fire && op_wr && op_in;
            mem_wdata = i_rx.rx_byte;
            mem_re    = in_fire && op_rd && op_in;
        end
    end

    bcmb_ram #(
        .WIDTH (bcmb_pkg::BYTE_W),
        .DEPTH (bcmb_pkg::MEM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_addr  (mem_addr),
        .i_we    (mem_we),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .o_rdata (mem_rdata)
    );

    // Emitter next state
    always_comb begin
        n_busy = r_busy;
        n_kind = r_kind;
        n_idx  = r_idx;
        n_oor  = r_oor;
        if (in_fire) begin
            n_busy = job_reply;
            n_kind = job_kind;
            n_idx  = 4'd0;
            if (op_rd) begin
                n_oor = !op_in;
            end
        end else if (job_done) begin
            n_busy = 1'b0;
        end else if (out_fire) begin
            n_idx = r_idx + 4'd1;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur      <= 8'h00;
            r_rem      <= 3'd0;
            r_seq      <= 1'b0;
            r_addr     <= 24'h000000;
            r_busy     <= 1'b0;
            r_kind     <= bcmb_pkg::RPL_ACK;
            r_idx      <= 4'd0;
            r_oor      <= 1'b0;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(bcmb_pkg::MEM_DEPTH - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            if (in_fire) begin
                r_cur  <= n_cur;
                r_rem  <= n_rem;
                r_seq  <= n_seq;
                r_addr <= n_addr;
            end
            r_busy <= n_busy;
            r_kind <= n_kind;
            r_idx  <= n_idx;
            r_oor  <= n_oor;
        end
    end

    // Reply byte selection
    logic [95:0] props_w;
    logic [3:0]  psel;
    logic [1:0]  ssel;
    logic [7:0]  mem_byte;
    logic [7:0]  ack_byte;

    assign props_w  = {r_props_hi, r_props_lo};
    assign psel     = 4'd12 - r_idx;
    assign ssel     = 2'd3 - r_idx[1:0];
    assign mem_byte = r_oor ? bcmb_pkg::ERASED_BYTE : mem_rdata;
    assign ack_byte = r_reply[7:0];

    always_comb begin
        unique case (r_kind)
            bcmb_pkg::RPL_PROPS:
                o_tx.tx_byte = (r_idx == 4'd0) ? ack_byte : props_w[{psel, 3'b000} +: 8];
            bcmb_pkg::RPL_SIZE:
                o_tx.tx_byte = (r_idx == 4'd0) ? ack_byte : r_mem_size[{ssel, 3'b000} +: 8];
            bcmb_pkg::RPL_ACK:
                o_tx.tx_byte = ack_byte;
            bcmb_pkg::RPL_UNIMP:
                o_tx.tx_byte = r_reply[15:8];
            bcmb_pkg::RPL_ACK_MEM:
                o_tx.tx_byte = (r_idx == 4'd0) ? ack_byte : mem_byte;
            bcmb_pkg::RPL_MEM:
                o_tx.tx_byte = mem_byte;
            default:
                o_tx.tx_byte = ack_byte;
        endcase
    end

    assign o_tx.valid         = r_busy;
    assign o_tx.last_of_reply = (r_idx == bcmb_pkg::last_index(r_kind));

endmodule

`default_nettype wire
